@@ sv/cartesian_to_spherical_assert.svh @@
// Assertion helpers for the cartesian_to_spherical port checker.
// C2S_ASSERT is disabled while reset is low; C2S_ASSERT_RST also checks during reset.
`ifndef CARTESIAN_TO_SPHERICAL_ASSERT_SVH
`define CARTESIAN_TO_SPHERICAL_ASSERT_SVH
`define C2S_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("c2s port check failed");
`define C2S_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("c2s port check failed around reset");
`endif

@@ sv/c2s_pkg.sv @@
package c2s_pkg;

  localparam int COORD_WIDTH    = 20;
  localparam int CORDIC_STAGES  = 16;
  localparam int CORD_GUARD     = 24;
  localparam int ATAN_TABLE_LEN = 24;
  localparam int STEP_IDX_W     = $clog2(ATAN_TABLE_LEN);

  // squared magnitudes and square roots
  localparam int SQ_W   = 2 * COORD_WIDTH;
  localparam int ROOT_W = COORD_WIDTH;
  localparam int DIST_W = 20;
  localparam int RND_W  = ((ROOT_W > DIST_W) ? ROOT_W : DIST_W) + 1;

  // CORDIC datapath
  localparam int DEN_W  = COORD_WIDTH + 1;
  localparam int CORD_W = COORD_WIDTH + CORD_GUARD + 3;
  localparam int ACC_W  = 25;

  // angle output
  localparam int ANG_SHIFT = 8;
  localparam int ANG_HALF  = 128;
  localparam int ANG_W     = ACC_W + 1 - ANG_SHIFT;
  localparam int AZ_W      = 17;
  localparam int EL_W      = 16;
  localparam int AZ_LIMIT  = 46080;
  localparam int EL_LIMIT  = 23040;

  // near-zero threshold register
  localparam int THR_W     = 12;
  localparam int THR_RESET = 4;
  localparam int CMP_W     = (ROOT_W > THR_W) ? ROOT_W : THR_W;

  typedef logic signed [ACC_W-1:0] acc_t;

  localparam acc_t ACC_QUARTER = acc_t'(90 * 65536);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
    logic        [COORD_WIDTH-1:0] ay;
  } side_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] num;
    logic signed [DEN_W-1:0]       den;
    logic                          zero;
  } vec_t;

  // atan(2^-i) in 1/65536 degree
  function automatic acc_t atan_step(input logic [STEP_IDX_W-1:0] idx);
    acc_t v;
    case (idx)
      STEP_IDX_W'(0):  v = acc_t'(2949120);
      STEP_IDX_W'(1):  v = acc_t'(1740967);
      STEP_IDX_W'(2):  v = acc_t'(919879);
      STEP_IDX_W'(3):  v = acc_t'(466945);
      STEP_IDX_W'(4):  v = acc_t'(234379);
      STEP_IDX_W'(5):  v = acc_t'(117304);
      STEP_IDX_W'(6):  v = acc_t'(58666);
      STEP_IDX_W'(7):  v = acc_t'(29335);
      STEP_IDX_W'(8):  v = acc_t'(14668);
      STEP_IDX_W'(9):  v = acc_t'(7334);
      STEP_IDX_W'(10): v = acc_t'(3667);
      STEP_IDX_W'(11): v = acc_t'(1833);
      STEP_IDX_W'(12): v = acc_t'(917);
      STEP_IDX_W'(13): v = acc_t'(458);
      STEP_IDX_W'(14): v = acc_t'(229);
      STEP_IDX_W'(15): v = acc_t'(115);
      STEP_IDX_W'(16): v = acc_t'(57);
      STEP_IDX_W'(17): v = acc_t'(29);
      STEP_IDX_W'(18): v = acc_t'(14);
      STEP_IDX_W'(19): v = acc_t'(7);
      STEP_IDX_W'(20): v = acc_t'(4);
      STEP_IDX_W'(21): v = acc_t'(2);
      STEP_IDX_W'(22): v = acc_t'(1);
      default:         v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/c2s_square.sv @@
module c2s_square (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic signed [c2s_pkg::COORD_WIDTH-1:0] pos_x_i,
  input  logic signed [c2s_pkg::COORD_WIDTH-1:0] pos_y_i,
  input  logic signed [c2s_pkg::COORD_WIDTH-1:0] pos_z_i,
  output logic                                  valid_o,
  output logic [c2s_pkg::SQ_W-1:0]              hsq_o,
  output logic [c2s_pkg::SQ_W-1:0]              dsq_o,
  output c2s_pkg::side_t                        side_o
);

  localparam int W      = c2s_pkg::COORD_WIDTH;
  localparam int SQ_W   = c2s_pkg::SQ_W;
  localparam int STAGES = 4;

  logic [STAGES-1:0] valid_q;
  c2s_pkg::side_t    side_q [STAGES];
  c2s_pkg::side_t    side_d;

  logic [W-1:0]    ax_d, ay_d, az_d;
  logic [W-1:0]    ax_q, az_q;
  logic [SQ_W-1:0] ax2_q, ay2_q, az2_q;
  logic [SQ_W-1:0] hsq3_q, ay2_3_q;
  logic [SQ_W-1:0] hsq_q, dsq_q;

  // magnitudes; the most negative value maps onto its own bit pattern, read unsigned
  assign ax_d = pos_x_i[W-1] ? W'(-pos_x_i) : W'(pos_x_i);
  assign ay_d = pos_y_i[W-1] ? W'(-pos_y_i) : W'(pos_y_i);
  assign az_d = pos_z_i[W-1] ? W'(-pos_z_i) : W'(pos_z_i);

  always_comb begin
    side_d    = '0;
    side_d.x  = pos_x_i;
    side_d.y  = pos_y_i;
    side_d.z  = pos_z_i;
    side_d.ay = ay_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_d;
      for (int i = 1; i < STAGES; i++) begin
        side_q[i] <= side_q[i-1];
      end
      ax_q    <= ax_d;
      az_q    <= az_d;
      ax2_q   <= ax_q * ax_q;
      ay2_q   <= side_q[0].ay * side_q[0].ay;
      az2_q   <= az_q * az_q;
      hsq3_q  <= ax2_q + az2_q;
      ay2_3_q <= ay2_q;
      hsq_q   <= hsq3_q;
      dsq_q   <= hsq3_q + ay2_3_q;
    end
  end

  assign valid_o = valid_q[STAGES-1];
  assign hsq_o   = hsq_q;
  assign dsq_o   = dsq_q;
  assign side_o  = side_q[STAGES-1];

endmodule

@@ sv/c2s_sqrt.sv @@
module c2s_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [c2s_pkg::SQ_W-1:0]      hsq_i,
  input  logic [c2s_pkg::SQ_W-1:0]      dsq_i,
  input  c2s_pkg::side_t                side_i,
  output logic                          valid_o,
  output logic [c2s_pkg::DIST_W-1:0]    dist_o,
  output logic [c2s_pkg::ROOT_W-1:0]    h_o,
  output c2s_pkg::side_t                side_o
);

  localparam int RT_W   = c2s_pkg::ROOT_W;
  localparam int SQ_W   = c2s_pkg::SQ_W;
  localparam int REM_W  = RT_W + 2;
  localparam int RND_W  = c2s_pkg::RND_W;
  localparam int DIST_W = c2s_pkg::DIST_W;
  localparam int NL     = 2;  // lane 0: full distance, lane 1: horizontal distance

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  logic [RT_W-1:0]  valid_q;
  logic [REM_W-1:0] rem_q  [RT_W][NL];
  logic [RT_W-1:0]  root_q [RT_W][NL];
  logic [SQ_W-1:0]  rad_q  [RT_W-1][NL];
  c2s_pkg::side_t   side_q [RT_W];

  logic                 rnd_valid_q;
  logic [DIST_W-1:0]    dist_q;
  logic [RT_W-1:0]      h_q;
  c2s_pkg::side_t       rnd_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      rnd_valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q     <= {valid_q[RT_W-2:0], valid_i};
      rnd_valid_q <= valid_q[RT_W-1];
    end
  end

  // one root bit per stage, restoring digit recurrence
  for (genvar k = 0; k < RT_W; k++) begin : g_step
    logic [REM_W-1:0] rem_p  [NL];
    logic [RT_W-1:0]  root_p [NL];
    logic [SQ_W-1:0]  rad_p  [NL];
    c2s_pkg::side_t   side_p;

    if (k == 0) begin : g_first
      for (genvar l = 0; l < NL; l++) begin : g_init
        assign rem_p[l]  = '0;
        assign root_p[l] = '0;
      end
      assign rad_p[0] = dsq_i;
      assign rad_p[1] = hsq_i;
      assign side_p   = side_i;
    end else begin : g_next
      for (genvar l = 0; l < NL; l++) begin : g_prev
        assign rem_p[l]  = rem_q[k-1][l];
        assign root_p[l] = root_q[k-1][l];
        assign rad_p[l]  = rad_q[k-1][l];
      end
      assign side_p = side_q[k-1];
    end

    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic [REM_W+1:0] rem_sh, trial, diff;
      logic             ge;

      assign rem_sh = {rem_p[l], rad_p[l][SQ_W-1 -: 2]};
      assign trial  = {2'b00, root_p[l], 2'b01};
      assign ge     = (rem_sh >= trial);
      assign diff   = rem_sh - trial;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k][l]  <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
          root_q[k][l] <= {root_p[l][RT_W-2:0], ge};
        end
      end

      if (k < RT_W - 1) begin : g_rad
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            rad_q[k][l] <= {rad_p[l][SQ_W-3:0], 2'b00};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_p;
      end
    end
  end

  // round to nearest: bump the root when the remainder exceeds it
  logic [RND_W-1:0] rnd_d [NL];

  for (genvar l = 0; l < NL; l++) begin : g_round
    logic up;
    assign up       = (rem_q[RT_W-1][l] > {2'b00, root_q[RT_W-1][l]});
    assign rnd_d[l] = RND_W'(root_q[RT_W-1][l]) + RND_W'(up);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dist_q     <= (rnd_d[0] > RND_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(rnd_d[0]);
      h_q        <= RT_W'(rnd_d[1]);
      rnd_side_q <= side_q[RT_W-1];
    end
  end

  assign valid_o = rnd_valid_q;
  assign dist_o  = dist_q;
  assign h_o     = h_q;
  assign side_o  = rnd_side_q;

endmodule

@@ sv/c2s_cordic.sv @@
module c2s_cordic (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  c2s_pkg::vec_t                 vec_i  [2],
  input  logic [c2s_pkg::DIST_W-1:0]    dist_i,
  output logic                          valid_o,
  output c2s_pkg::acc_t                 acc_o  [2],
  output logic                          zero_o [2],
  output logic [c2s_pkg::DIST_W-1:0]    dist_o
);

  localparam int N     = c2s_pkg::CORDIC_STAGES;
  localparam int CW    = c2s_pkg::CORD_W;
  localparam int G     = c2s_pkg::CORD_GUARD;
  localparam int DEN_W = c2s_pkg::DEN_W;
  localparam int NUM_W = c2s_pkg::COORD_WIDTH;
  localparam int IDX_W = c2s_pkg::STEP_IDX_W;
  localparam int NL    = 2;

  logic [N:0]                   valid_q;
  logic signed [CW-1:0]         re_q   [N][NL];
  logic signed [CW-1:0]         im_q   [N][NL];
  c2s_pkg::acc_t                acc_q  [N+1][NL];
  logic                         zero_q [N+1][NL];
  logic [c2s_pkg::DIST_W-1:0]   dist_q [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[N-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dist_q[0] <= dist_i;
      for (int i = 1; i <= N; i++) begin
        dist_q[i] <= dist_q[i-1];
      end
    end
  end

  for (genvar l = 0; l < NL; l++) begin : g_lane
    logic signed [CW-1:0] re0, im0;

    assign re0 = {{(CW-DEN_W-G){vec_i[l].den[DEN_W-1]}}, vec_i[l].den, {G{1'b0}}};
    assign im0 = {{(CW-NUM_W-G){vec_i[l].num[NUM_W-1]}}, vec_i[l].num, {G{1'b0}}};

    // bring a vector with negative real part into the right half-plane
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[0][l] <= vec_i[l].zero;
        if (re0[CW-1]) begin
          if (!im0[CW-1]) begin
            re_q[0][l]  <= im0;
            im_q[0][l]  <= -re0;
            acc_q[0][l] <= c2s_pkg::ACC_QUARTER;
          end else begin
            re_q[0][l]  <= -im0;
            im_q[0][l]  <= re0;
            acc_q[0][l] <= -c2s_pkg::ACC_QUARTER;
          end
        end else begin
          re_q[0][l]  <= re0;
          im_q[0][l]  <= im0;
          acc_q[0][l] <= '0;
        end
      end
    end

    for (genvar k = 0; k < N; k++) begin : g_iter
      logic signed [CW-1:0] rs, is;
      c2s_pkg::acc_t        tab;
      logic                 up;

      assign rs  = re_q[k][l] >>> k;
      assign is  = im_q[k][l] >>> k;
      assign tab = c2s_pkg::atan_step(IDX_W'(k));
      assign up  = !im_q[k][l][CW-1];

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          acc_q[k+1][l]  <= up ? acc_q[k][l] + tab : acc_q[k][l] - tab;
          zero_q[k+1][l] <= zero_q[k][l];
        end
      end

      if (k < N - 1) begin : g_vec
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            re_q[k+1][l] <= up ? re_q[k][l] + is : re_q[k][l] - is;
            im_q[k+1][l] <= up ? im_q[k][l] - rs : im_q[k][l] + rs;
          end
        end
      end
    end

    assign acc_o[l]  = acc_q[N][l];
    assign zero_o[l] = zero_q[N][l];
  end

  assign valid_o = valid_q[N];
  assign dist_o  = dist_q[N];

endmodule

@@ sv/cartesian_to_spherical.sv @@
// Pipeline: magnitudes and squares, rounded square roots, CORDIC vectoring, then the output register.
// Throughput: one transaction per cycle; every square-root bit and every CORDIC iteration
// owns a register stage, so the unrolled pipeline takes a new position on each unstalled clock.
// Stalls: a held output freezes the whole pipeline; nothing is dropped or repeated.
// Reset: asynchronous, active low; clears all valid bits and loads the threshold with 4.
module cartesian_to_spherical (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // position input channel
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [c2s_pkg::COORD_WIDTH-1:0] pos_x_i,
  input  logic signed [c2s_pkg::COORD_WIDTH-1:0] pos_y_i,
  input  logic signed [c2s_pkg::COORD_WIDTH-1:0] pos_z_i,
  // near-zero threshold register
  input  logic                                   cfg_we_i,
  input  logic [c2s_pkg::THR_W-1:0]              cfg_wdata_i,
  // spherical result channel
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [c2s_pkg::DIST_W-1:0]             distance_o,
  output logic signed [c2s_pkg::AZ_W-1:0]        azimuth_o,
  output logic signed [c2s_pkg::EL_W-1:0]        elevation_o
);

  localparam int ACC_W = c2s_pkg::ACC_W;
  localparam int ANG_W = c2s_pkg::ANG_W;
  localparam int CMP_W = c2s_pkg::CMP_W;

  localparam logic signed [ANG_W-1:0] AZ_MAX = ANG_W'(c2s_pkg::AZ_LIMIT);
  localparam logic signed [ANG_W-1:0] EL_MAX = ANG_W'(c2s_pkg::EL_LIMIT);

  // Global advance: the pipeline moves whenever the output register is empty or being
  // drained. Input ready follows it directly, so a transaction is taken in the same
  // cycle as a result leaves.
  logic adv;

  logic [c2s_pkg::THR_W-1:0] thr_q;

  // squares stage outputs
  logic                        sq_valid;
  logic [c2s_pkg::SQ_W-1:0]    sq_hsq, sq_dsq;
  c2s_pkg::side_t              sq_side;

  // square-root stage outputs
  logic                        rt_valid;
  logic [c2s_pkg::DIST_W-1:0]  rt_dist;
  logic [c2s_pkg::ROOT_W-1:0]  rt_h;
  c2s_pkg::side_t              rt_side;

  // CORDIC operands and results
  c2s_pkg::vec_t               cd_vec  [2];
  logic                        cd_valid;
  c2s_pkg::acc_t               cd_acc  [2];
  logic                        cd_zero [2];
  logic [c2s_pkg::DIST_W-1:0]  cd_dist;

  logic                        near_zero;
  logic signed [ACC_W:0]       az_sum, el_sum;
  logic signed [ANG_W-1:0]     az_ang, el_ang, az_clip, el_clip;

  logic                        out_valid_q;
  logic [c2s_pkg::DIST_W-1:0]  dist_q;
  logic signed [c2s_pkg::AZ_W-1:0] az_q;
  logic signed [c2s_pkg::EL_W-1:0] el_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // Threshold register; software writes it only while the block is idle, which the block itself does not enforce.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= c2s_pkg::THR_W'(c2s_pkg::THR_RESET);
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Magnitudes, squares and the two squared distances.
  c2s_square u_square (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .pos_x_i (pos_x_i),
    .pos_y_i (pos_y_i),
    .pos_z_i (pos_z_i),
    .valid_o (sq_valid),
    .hsq_o   (sq_hsq),
    .dsq_o   (sq_dsq),
    .side_o  (sq_side)
  );

  // Rounded square roots of both squared distances, side by side.
  c2s_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sq_valid),
    .hsq_i   (sq_hsq),
    .dsq_i   (sq_dsq),
    .side_i  (sq_side),
    .valid_o (rt_valid),
    .dist_o  (rt_dist),
    .h_o     (rt_h),
    .side_o  (rt_side)
  );

  // Elevation is held at zero near the origin: both the horizontal distance and |y|
  // must sit below the threshold, so a threshold of zero never forces it.
  assign near_zero = (CMP_W'(rt_h) < CMP_W'(thr_q)) && (CMP_W'(rt_side.ay) < CMP_W'(thr_q));

  // Lane 0 is azimuth, atan2(x, z); lane 1 is elevation, atan2(y, h).
  // A lane whose operands are both zero reports a zero angle.
  always_comb begin
    cd_vec[0]      = '0;
    cd_vec[0].num  = rt_side.x;
    cd_vec[0].den  = c2s_pkg::DEN_W'(rt_side.z);
    cd_vec[0].zero = (rt_side.x == '0) && (rt_side.z == '0);
    cd_vec[1]      = '0;
    cd_vec[1].num  = rt_side.y;
    cd_vec[1].den  = {1'b0, rt_h};
    cd_vec[1].zero = ((rt_side.y == '0) && (rt_h == '0)) || near_zero;
  end

  c2s_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (rt_valid),
    .vec_i   (cd_vec),
    .dist_i  (rt_dist),
    .valid_o (cd_valid),
    .acc_o   (cd_acc),
    .zero_o  (cd_zero),
    .dist_o  (cd_dist)
  );

  // Scale 1/65536 degree down to 1/256 degree, rounding half up (floor of acc + 128).
  assign az_sum = (ACC_W+1)'(cd_acc[0]) + (ACC_W+1)'(c2s_pkg::ANG_HALF);
  assign el_sum = (ACC_W+1)'(cd_acc[1]) + (ACC_W+1)'(c2s_pkg::ANG_HALF);
  assign az_ang = az_sum[ACC_W:c2s_pkg::ANG_SHIFT];
  assign el_ang = el_sum[ACC_W:c2s_pkg::ANG_SHIFT];

  // Clamp CORDIC overshoot to the legal angle range; drop to zero when flagged.
  always_comb begin
    if (cd_zero[0]) begin
      az_clip = '0;
    end else if (az_ang > AZ_MAX) begin
      az_clip = AZ_MAX;
    end else if (az_ang < -AZ_MAX) begin
      az_clip = -AZ_MAX;
    end else begin
      az_clip = az_ang;
    end

    if (cd_zero[1]) begin
      el_clip = '0;
    end else if (el_ang > EL_MAX) begin
      el_clip = EL_MAX;
    end else if (el_ang < -EL_MAX) begin
      el_clip = -EL_MAX;
    end else begin
      el_clip = el_ang;
    end
  end

  // Output register: hold the result until the consumer takes the transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= cd_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dist_q <= cd_dist;
      az_q   <= c2s_pkg::AZ_W'(az_clip);
      el_q   <= c2s_pkg::EL_W'(el_clip);
    end
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = dist_q;
  assign azimuth_o   = az_q;
  assign elevation_o = el_q;

endmodule

@@ sv/c2s_checker.sv @@
`include "cartesian_to_spherical_assert.svh"

module c2s_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [c2s_pkg::DIST_W-1:0]       distance_o,
  input logic signed [c2s_pkg::AZ_W-1:0]  azimuth_o,
  input logic signed [c2s_pkg::EL_W-1:0]  elevation_o
);

  // no result shows while reset is held
  `C2S_ASSERT_RST(a_rst_no_out, !rst_ni |-> !out_valid_o)

  // a blocked result must stall the input side
  `C2S_ASSERT(a_stall_back, out_valid_o && !out_ready_i |-> !in_ready_o)

  // an empty output register always lets a transaction in
  `C2S_ASSERT(a_free_ready, !out_valid_o |-> in_ready_o)

  // angles stay within their clamped ranges
  `C2S_ASSERT(a_ang_range, out_valid_o |-> (azimuth_o <= c2s_pkg::AZ_LIMIT) && (azimuth_o >= -c2s_pkg::AZ_LIMIT) && (elevation_o <= c2s_pkg::EL_LIMIT) && (elevation_o >= -c2s_pkg::EL_LIMIT))

  // a stalled result holds
  `C2S_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(distance_o) && $stable(azimuth_o) && $stable(elevation_o))

endmodule

bind cartesian_to_spherical c2s_checker u_c2s_checker (.*);
